>>> hdl/ppq_pkg.sv
`default_nettype none

package ppq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 16;
    localparam int PRIO_W    = 8;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_EXEC   = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   proc_id;
        logic [PRIO_W-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] out_priority;
        logic              last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_req;
        logic       insert;
        logic       pop;
        logic       out_load;
        logic [1:0] out_status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_kind;
        logic full;
        logic empty;
        logic pop_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> hdl/ppq_dp.sv
`default_nettype none

module ppq_dp
    import ppq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire req_t s_req,
    input  wire logic m_ready,
    output logic      m_valid,
    output rsp_t      m_rsp,
    input  wire cmd_t cmd,
    output sts_t      sts
);

    localparam int CW = $clog2(DEPTH + 1);

    // Entry 0 holds the highest priority; equal priorities keep arrival order.
    logic [ID_W-1:0]   id_reg   [DEPTH];
    logic [PRIO_W-1:0] prio_reg [DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    req_t              req_reg;
    rsp_t              rsp_reg;
    logic              m_valid_reg;
    logic [DEPTH:0]    ge_ext;

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg <= s_req;
        end
    end

    // ge_ext[i+1]: entry i is occupied and outranks or ties the new entry
    always_comb begin
        ge_ext[0] = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
            ge_ext[i+1] = (count_reg > CW'(i)) && (prio_reg[i] >= req_reg.priority_req);
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (cmd.insert && !ge_ext[i+1]) begin
                if (ge_ext[i]) begin
                    id_reg[i]   <= req_reg.proc_id;
                    prio_reg[i] <= req_reg.priority_req;
                end else begin
                    if (i > 0) begin
                        id_reg[i]   <= id_reg[(i > 0) ? i - 1 : 0];
                        prio_reg[i] <= prio_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end else if (cmd.pop && (i < DEPTH - 1)) begin
                id_reg[i]   <= id_reg[(i < DEPTH - 1) ? i + 1 : i];
                prio_reg[i] <= prio_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign sts.in_kind  = s_req.kind;
    assign sts.full     = (count_reg == CW'(DEPTH));
    assign sts.empty    = (count_reg == '0);
    assign sts.pop_last = (count_reg == CW'(1)) || (prio_reg[1] != prio_reg[0]);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            rsp_reg.status <= cmd.out_status;
            if (cmd.pop) begin
                rsp_reg.out_id       <= id_reg[0];
                rsp_reg.out_priority <= prio_reg[0];
                rsp_reg.last         <= sts.pop_last;
            end else begin
                rsp_reg.out_id       <= '0;
                rsp_reg.out_priority <= '0;
                rsp_reg.last         <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

endmodule

`default_nettype wire

>>> hdl/ppq_ctrl.sv
`default_nettype none

module ppq_ctrl
    import ppq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INS  = 2'd1;
    localparam logic [1:0] ST_EXE  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.out_status = STATUS_OK;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = (sts.in_kind == KIND_EXEC) ? ST_EXE : ST_INS;
                end
            end
            ST_INS: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.insert     = !sts.full;
                    cmd.out_status = sts.full ? STATUS_FULL : STATUS_OK;
                    state_next     = ST_IDLE;
                end
            end
            ST_EXE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.empty) begin
                        cmd.out_status = STATUS_EMPTY;
                        state_next     = ST_IDLE;
                    end else begin
                        cmd.pop = 1'b1;
                        if (sts.pop_last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.insert |-> !sts.full)
        else $error("insert into full store");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> !sts.empty)
        else $error("pop from empty store");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop && sts.pop_last) |=> s_ready)
        else $error("execute did not finish after last entry");

endmodule

`default_nettype wire

>>> hdl/process_priority_queue.sv
// Process priority queue: up to DEPTH (id, priority) entries, highest priority first.
// Insert request: taken when idle; result registered once the output register is free.
// Execute request: taken when idle, then one result per cycle for each removed entry;
// the output register stalls the sequencer while m_ready is low.
// Reset (aresetn low at a clock edge) empties the queue and drops any pending result.
`default_nettype none

module process_priority_queue
    import ppq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // request channel
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_req,

    // result channel
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_rsp
);

    // Control and status between sequencer and entry store
    cmd_t cmd;
    sts_t sts;

    // Sequencer: idle -> insert (one step) or execute (one step per removed entry).
    ppq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Entry store: sorted shift array with parallel compare for insert,
    // shift toward the head for removal, plus the result register.
    ppq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_rsp   (m_rsp),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire
